/* rtl/mf3_pkg.sv */
package mf3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4095;
  localparam int MIN_DIM    = 3;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 24;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 11;
  localparam int DIM_W      = 12;
  localparam int CFG_W      = 24;
  localparam int IDX_W      = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_FILL_COLOR   = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [PIX_W-1:0] FILL_RESET   = 24'd255;

  // Bit positions of the result slots one request can produce, in output order.
  localparam int SLOT_DIAG   = 0;  // (r-1, c-1)
  localparam int SLOT_RIGHT  = 1;  // (r-1, c)   at the last column
  localparam int SLOT_BELOW  = 2;  // (r, c-1)   on the last row
  localparam int SLOT_CORNER = 3;  // (r, c)     last row and last column
  localparam int SLOTS       = 4;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } mf3_col_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [SLOTS-1:0] mask;
  } mf3_meta_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic mf3_col_t sort3(pix_t a, pix_t b, pix_t c);
    pix_t l1;
    pix_t h1;
    pix_t m2;
    mf3_col_t s;
    l1    = min2(a, b);
    h1    = max2(a, b);
    s.hi  = max2(h1, c);
    m2    = min2(h1, c);
    s.lo  = min2(l1, m2);
    s.mid = max2(l1, m2);
    return s;
  endfunction

endpackage

/* rtl/median_filter_3x3.sv */
// Channel   Direction  Handshake               Payload
// config    in         cfg_we_i                cfg_idx_i, cfg_data_i
// pixels    in         in_valid_i / in_stall_o pixel_word_i
// results   out        out_valid_o/out_stall_i out_pixel_o, out_row_o, out_col_o,
//                                              is_border_o, last_o
//
// One request is taken per cycle while in_stall_o is low. It yields zero to four results,
// sent one per cycle while the output is not stalled, so a pixel at the last column or on
// the last row yields up to two results and the last pixel of a frame four.
// A request moves through stages 1 to 3 and the expansion stage to the output register.
// Reset clears the counters and the window and restores the default configuration; the
// line stores are not cleared. A result stall raises in_stall_o once a result waits.
module median_filter_3x3
  import mf3_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [PIX_W-1:0]  pixel_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PIX_W-1:0]  out_pixel_o,
  output logic [ROW_W-1:0]  out_row_o,
  output logic [COL_W-1:0]  out_col_o,
  output logic              is_border_o,
  output logic              last_o
);

  // Configuration.
  logic [DIM_W-1:0] width_q, height_q;
  pix_t             fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      fill_q   <= FILL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        REG_FILL_COLOR:   fill_q   <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff, h_eff, w_lim, h_lim;

  always_comb begin
    if (width_q < DIM_W'(MIN_DIM)) begin
      w_eff = DIM_W'(MIN_DIM);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    w_lim = w_eff - DIM_W'(1);
    h_lim = h_eff - DIM_W'(1);
  end

  // Pipeline control: every stage moves together when the expansion stage can
  // take the next request.
  logic go;
  logic in_acc;
  assign in_acc     = in_valid_i && go;
  assign in_stall_o = !go;

  // Position counters.
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             last_col, last_row;
  mf3_meta_t        meta_in;

  always_comb begin
    last_col = DIM_W'(col_q) >= w_lim;
    last_row = DIM_W'(row_q) >= h_lim;
    meta_in.row = row_q;
    meta_in.col = col_q;
    meta_in.mask[SLOT_DIAG]   = (row_q != '0) && (col_q != '0);
    meta_in.mask[SLOT_RIGHT]  = (row_q != '0) && last_col;
    meta_in.mask[SLOT_BELOW]  = last_row && (col_q != '0);
    meta_in.mask[SLOT_CORNER] = last_row && last_col;
    row_d = row_q;
    col_d = col_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Stage 1: line store read data arrives. Consecutive requests always touch
  // different columns, so the write-back never meets a pending read.
  logic      s1_valid_q;
  pix_t      s1_pix_q;
  mf3_meta_t s1_meta_q;
  pix_t      upper_rd, middle_rd;
  logic      ls_we;

  assign ls_we = go && s1_valid_q;

  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (s1_meta_q.col[ADDR_W-1:0]),
    .wdata_i (middle_rd),
    .re_i    (in_acc),
    .raddr_i (col_q[ADDR_W-1:0]),
    .rdata_o (upper_rd)
  );

  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (s1_meta_q.col[ADDR_W-1:0]),
    .wdata_i (s1_pix_q),
    .re_i    (in_acc),
    .raddr_i (col_q[ADDR_W-1:0]),
    .rdata_o (middle_rd)
  );

  // Stage 2: window of three columns, each kept sorted since only the set of
  // nine values matters for the median.
  logic      s2_valid_q;
  mf3_meta_t s2_meta_q;
  mf3_col_t  win_q [3];

  // Stage 3: max of lows, median of middles, min of highs.
  logic      s3_valid_q;
  mf3_meta_t s3_meta_q;
  pix_t      s3_lo_q, s3_mid_q, s3_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win_q[i] <= '0;
      end
    end else if (go) begin
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (s1_valid_q) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= sort3(upper_rd, middle_rd, s1_pix_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_pix_q  <= pixel_word_i;
      s1_meta_q <= meta_in;
      s2_meta_q <= s1_meta_q;
      s3_meta_q <= s2_meta_q;
      s3_lo_q   <= max3(win_q[0].lo, win_q[1].lo, win_q[2].lo);
      s3_mid_q  <= med3(win_q[0].mid, win_q[1].mid, win_q[2].mid);
      s3_hi_q   <= min3(win_q[0].hi, win_q[1].hi, win_q[2].hi);
    end
  end

  // Expansion stage: hands out the pending result slots one per cycle while the output is free.
  logic [SLOTS-1:0] e_mask_q, e_mask_d, e_rest;
  logic [ROW_W-1:0] e_row_q;
  logic [COL_W-1:0] e_col_q;
  pix_t             e_med_q;
  logic             o_free, emit;
  logic             prev_row, prev_col;
  logic [ROW_W-1:0] sel_row;
  logic [COL_W-1:0] sel_col;
  logic             sel_border;

  assign o_free = !out_valid_o || !out_stall_i;
  assign e_rest = e_mask_q & (e_mask_q - SLOTS'(1));
  assign emit   = (e_mask_q != '0) && o_free;
  assign go     = (e_mask_q == '0) || (emit && (e_rest == '0));

  always_comb begin
    e_mask_d = e_mask_q;
    if (go) begin
      e_mask_d = s3_valid_q ? s3_meta_q.mask : '0;
    end else if (emit) begin
      e_mask_d = e_rest;
    end
  end

  always_comb begin
    prev_row = 1'b0;
    prev_col = 1'b0;
    if (e_mask_q[SLOT_DIAG]) begin
      prev_row = 1'b1;
      prev_col = 1'b1;
    end else if (e_mask_q[SLOT_RIGHT]) begin
      prev_row = 1'b1;
    end else if (e_mask_q[SLOT_BELOW]) begin
      prev_col = 1'b1;
    end
    sel_row    = e_row_q - ROW_W'(prev_row);
    sel_col    = e_col_q - COL_W'(prev_col);
    sel_border = (sel_row == '0) || (DIM_W'(sel_row) >= h_lim) ||
                 (sel_col == '0) || (DIM_W'(sel_col) >= w_lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_mask_q <= '0;
    end else begin
      e_mask_q <= e_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && s3_valid_q) begin
      e_row_q <= s3_meta_q.row;
      e_col_q <= s3_meta_q.col;
      e_med_q <= med3(s3_lo_q, s3_mid_q, s3_hi_q);
    end
  end

  // Output register.
  logic             o_valid_q;
  pix_t             o_pixel_q;
  logic [ROW_W-1:0] o_row_q;
  logic [COL_W-1:0] o_col_q;
  logic             o_border_q, o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (emit) begin
      o_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_pixel_q  <= sel_border ? fill_q : e_med_q;
      o_row_q    <= sel_row;
      o_col_q    <= sel_col;
      o_border_q <= sel_border;
      o_last_q   <= (e_rest == '0);
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_pixel_o = o_pixel_q;
  assign out_row_o   = o_row_q;
  assign out_col_o   = o_col_q;
  assign is_border_o = o_border_q;
  assign last_o      = o_last_q;

endmodule

/* rtl/mf3_ram.sv */
module mf3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds until the next read.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mf3_checker.sv */
module mf3_checker
  import mf3_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [PIX_W-1:0]  out_pixel_o,
  input logic [ROW_W-1:0]  out_row_o,
  input logic [COL_W-1:0]  out_col_o,
  input logic              is_border_o,
  input logic              last_o
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_pixel_o) &&
      $stable(out_row_o) && $stable(out_col_o) && $stable(is_border_o) &&
      $stable(last_o))
    else $error("stalled result changed");

  // Results of one request leave back to back.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a result burst");

  // A median result never sits on the top row or the left column.
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_border_o |-> (out_row_o != '0) && (out_col_o != '0))
    else $error("median on the frame edge");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);
